FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define TCMB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, clocked on clk, off during reset
`define TCMB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/tcmb_pkg.sv
// Types and constants of the text column map builder
`timescale 1ns / 1ps

package tcmb_pkg;

  localparam int BYTE_W  = 8;
  localparam int COL_W   = 9;
  localparam int OFS_W   = 10;
  localparam int SIZE_W  = 6;
  localparam int TABW_W  = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [OFS_W-1:0] OFFSET_MAX = 10'd1023;
  localparam logic [TABW_W-1:0] TAB_LOG2_MAX = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_MODE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DBL_ENCODING   = 2'd2;

  localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DIGIT0  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_DIGIT9  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5a;
  localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7a;
  localparam logic [BYTE_W-1:0] CH_USCORE  = 8'h5f;
  localparam logic [BYTE_W-1:0] SJIS_LO1   = 8'h81;
  localparam logic [BYTE_W-1:0] SJIS_HI1   = 8'h9f;
  localparam logic [BYTE_W-1:0] SJIS_LO2   = 8'he0;
  localparam logic [BYTE_W-1:0] SJIS_HI2   = 8'hfc;
  localparam logic [BYTE_W-1:0] EUC_SS2    = 8'h8e;

  typedef enum logic [2:0] {
    CLS_NONE  = 3'd0,
    CLS_CODE  = 3'd1,
    CLS_SPACE = 3'd2,
    CLS_LABEL = 3'd3,
    CLS_KANJI = 3'd4
  } char_class_t;

  typedef struct packed {
    char_class_t            cls;
    logic [SIZE_W-1:0]      size;
    logic                   skip;
  } byte_info_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

endpackage

FILE: rtl/tcmb_decode.sv
// Byte decoder: character class, column width and trail-byte flag
`timescale 1ns / 1ps

module tcmb_decode (
  input  logic [tcmb_pkg::BYTE_W-1:0] text_byte,
  input  logic [tcmb_pkg::TABW_W-1:0] tab_width_log2,
  input  logic                        dbl_encoding,
  input  logic [4:0]                  col_low,
  output tcmb_pkg::byte_info_t        info
);

  logic [tcmb_pkg::TABW_W-1:0] sh;
  logic [tcmb_pkg::SIZE_W-1:0] tab_w;
  logic [tcmb_pkg::SIZE_W-1:0] tab_mask;
  logic                        sjis_lead;

  assign sh       = (tab_width_log2 > tcmb_pkg::TAB_LOG2_MAX) ? tcmb_pkg::TAB_LOG2_MAX
                                                               : tab_width_log2;
  assign tab_w    = tcmb_pkg::SIZE_W'(1) << sh;
  assign tab_mask = tab_w - tcmb_pkg::SIZE_W'(1);
  assign sjis_lead = (text_byte >= tcmb_pkg::SJIS_LO1 && text_byte <= tcmb_pkg::SJIS_HI1) ||
                     (text_byte >= tcmb_pkg::SJIS_LO2 && text_byte <= tcmb_pkg::SJIS_HI2);

  always_comb begin
    info.cls = tcmb_pkg::CLS_CODE;
    if (text_byte[7]) begin
      info.cls = tcmb_pkg::CLS_KANJI;
    end else if (text_byte == tcmb_pkg::CH_TAB || text_byte == tcmb_pkg::CH_SPACE) begin
      info.cls = tcmb_pkg::CLS_SPACE;
    end else if ((text_byte >= tcmb_pkg::CH_DIGIT0  && text_byte <= tcmb_pkg::CH_DIGIT9)  ||
                 (text_byte >= tcmb_pkg::CH_UPPER_A && text_byte <= tcmb_pkg::CH_UPPER_Z) ||
                 (text_byte >= tcmb_pkg::CH_LOWER_A && text_byte <= tcmb_pkg::CH_LOWER_Z) ||
                 text_byte == tcmb_pkg::CH_USCORE) begin
      info.cls = tcmb_pkg::CLS_LABEL;
    end

    info.size = tcmb_pkg::SIZE_W'(1);
    info.skip = 1'b0;
    if (text_byte == tcmb_pkg::CH_TAB) begin
      info.size = tab_w - ({1'b0, col_low} & tab_mask);
    end else if (text_byte[7]) begin
      if (dbl_encoding) begin
        info.skip = 1'b1;
        if (text_byte != tcmb_pkg::EUC_SS2) begin
          info.size = tcmb_pkg::SIZE_W'(2);
        end
      end else if (sjis_lead) begin
        info.skip = 1'b1;
        info.size = tcmb_pkg::SIZE_W'(2);
      end
    end
  end

endmodule

FILE: rtl/text_column_map_builder_top.sv
// A byte is taken in S_IDLE, then one map entry leaves per cycle while the output does not stall:
// 1..32 entries for a byte that fills columns, none for a byte that fills none, one for an
// end-of-line word. The single column counter steps per column entry; a line end clears it.
// An output stall holds the sequencer and the input; input reopens once the last entry is loaded.
// Reset (rst_n low, synchronous) clears line state and loads registers with 3, 0 and 1.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_column_map_builder_top #(
  parameter int LINE_COLUMNS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // line_done
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [8:0] column, [18:9] text_offset, [23:19] zero
  output logic        out_tlast,  // last_of_run
  output logic        out_tuser,  // [0] line_end_entry
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_wdata
);

  localparam int CNT_W = $clog2(LINE_COLUMNS + 32);

  logic [tcmb_pkg::TABW_W-1:0]  tab_log2_r;
  logic                         word_mode_r;
  logic                         dbl_enc_r;

  tcmb_pkg::state_t             state_r;
  logic [CNT_W-1:0]             col_cnt_r;
  logic [tcmb_pkg::OFS_W-1:0]   byte_ofs_r;
  logic [tcmb_pkg::OFS_W-1:0]   anchor_r;
  logic [tcmb_pkg::OFS_W-1:0]   anchor_nxt;
  tcmb_pkg::char_class_t        prev_cls_r;
  tcmb_pkg::char_class_t        prev_cls_nxt;
  logic                         skip_r;
  logic                         stopped_r;
  logic [tcmb_pkg::SIZE_W-1:0]  rem_r;
  logic                         end_pend_r;

  logic                         out_valid_r;
  logic [tcmb_pkg::COL_W-1:0]   out_col_r;
  logic [tcmb_pkg::OFS_W-1:0]   out_ofs_r;
  logic                         out_last_r;
  logic                         out_end_r;

  tcmb_pkg::byte_info_t         info;
  logic                         in_acc;
  logic                         load_entry;
  logic [tcmb_pkg::OFS_W-1:0]   ofs_inc;

  tcmb_decode u_decode (
    .text_byte      (in_tdata),
    .tab_width_log2 (tab_log2_r),
    .dbl_encoding   (dbl_enc_r),
    .col_low        (col_cnt_r[4:0]),
    .info           (info)
  );

  assign in_tready  = (state_r == tcmb_pkg::S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign load_entry = (state_r == tcmb_pkg::S_EMIT) && (!out_valid_r || out_tready);
  assign ofs_inc    = (byte_ofs_r < tcmb_pkg::OFFSET_MAX) ? byte_ofs_r + tcmb_pkg::OFS_W'(1)
                                                           : byte_ofs_r;

  always_comb begin
    prev_cls_nxt = prev_cls_r;
    anchor_nxt   = byte_ofs_r;
    if (word_mode_r) begin
      anchor_nxt = anchor_r;
      if (info.cls != prev_cls_r || info.cls == tcmb_pkg::CLS_CODE) begin
        prev_cls_nxt = info.cls;
        anchor_nxt   = byte_ofs_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_log2_r  <= 3'd3;
      word_mode_r <= 1'b0;
      dbl_enc_r   <= 1'b1;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        tcmb_pkg::REG_TAB_WIDTH_LOG2: tab_log2_r  <= cfg_wdata;
        tcmb_pkg::REG_WORD_MODE:      word_mode_r <= cfg_wdata[0];
        tcmb_pkg::REG_DBL_ENCODING:   dbl_enc_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcmb_pkg::S_IDLE;
      col_cnt_r   <= '0;
      byte_ofs_r  <= '0;
      anchor_r    <= '0;
      prev_cls_r  <= tcmb_pkg::CLS_NONE;
      skip_r      <= 1'b0;
      stopped_r   <= 1'b0;
      rem_r       <= '0;
      end_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_entry) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        tcmb_pkg::S_IDLE: begin
          if (in_acc) begin
            if (in_tlast) begin
              end_pend_r <= 1'b1;
              rem_r      <= tcmb_pkg::SIZE_W'(1);
              state_r    <= tcmb_pkg::S_EMIT;
            end else if (stopped_r) begin
              // rest of line ignored
            end else if (skip_r) begin
              skip_r     <= 1'b0;
              byte_ofs_r <= ofs_inc;
            end else if (col_cnt_r >= CNT_W'(LINE_COLUMNS)) begin
              stopped_r  <= 1'b1;
            end else begin
              anchor_r   <= anchor_nxt;
              prev_cls_r <= prev_cls_nxt;
              skip_r     <= info.skip;
              byte_ofs_r <= ofs_inc;
              rem_r      <= info.size;
              end_pend_r <= 1'b0;
              state_r    <= tcmb_pkg::S_EMIT;
            end
          end
        end
        tcmb_pkg::S_EMIT: begin
          if (load_entry) begin
            if (end_pend_r) begin
              col_cnt_r  <= '0;
              byte_ofs_r <= '0;
              anchor_r   <= '0;
              prev_cls_r <= tcmb_pkg::CLS_NONE;
              skip_r     <= 1'b0;
              stopped_r  <= 1'b0;
              end_pend_r <= 1'b0;
              rem_r      <= '0;
              state_r    <= tcmb_pkg::S_IDLE;
            end else begin
              col_cnt_r  <= col_cnt_r + CNT_W'(1);
              rem_r      <= rem_r - tcmb_pkg::SIZE_W'(1);
              if (rem_r == tcmb_pkg::SIZE_W'(1)) begin
                state_r  <= tcmb_pkg::S_IDLE;
              end
            end
          end
        end
        default: state_r <= tcmb_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_entry) begin
      out_col_r  <= tcmb_pkg::COL_W'(col_cnt_r);
      out_ofs_r  <= end_pend_r ? byte_ofs_r : anchor_r;
      out_last_r <= end_pend_r || (rem_r == tcmb_pkg::SIZE_W'(1));
      out_end_r  <= end_pend_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_ofs_r, out_col_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_end_r;

  `TCMB_ASSERT_IMP(a_emit_has_work, state_r == tcmb_pkg::S_EMIT, rem_r != '0)
  `TCMB_ASSERT_IMP(a_end_is_last, out_valid_r && out_end_r, out_last_r)
  `TCMB_ASSERT_NXT(a_line_end_emits, in_acc && in_tlast, state_r == tcmb_pkg::S_EMIT && end_pend_r)

endmodule
